FILE: src/twrl_pkg.sv
// Package for the tenant window rate limiter.
// Holds event codes, verdict codes, register indexes and field widths.
// No dependencies.
package twrl_pkg;

  localparam int unsigned CntW   = 64;
  localparam int unsigned StampW = 32;
  localparam int unsigned MibW   = 20;
  localparam int unsigned MibSh  = 20;
  localparam int unsigned OpsW   = 32;
  localparam int unsigned ConnW  = 16;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  typedef enum logic [2:0] {
    FUNC_SENT  = 3'd0,
    FUNC_RECV  = 3'd1,
    FUNC_OP    = 3'd2,
    FUNC_CHECK = 3'd3,
    FUNC_CPU   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    VERD_NONE    = 3'd0,
    VERD_INGRESS = 3'd1,
    VERD_EGRESS  = 3'd2,
    VERD_OPS     = 3'd3,
    VERD_CONNS   = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    REG_INGRESS_LIMIT = 2'd0,
    REG_EGRESS_LIMIT  = 2'd1,
    REG_OPS_LIMIT     = 2'd2,
    REG_CONN_LIMIT    = 2'd3
  } reg_idx_t;

endpackage

FILE: src/tenant_window_rate_limiter.sv
// Top level of the tenant window rate limiter: input register, one pass of
// accounting and limit checks, and the counter state that forms the result.
// Depends on twrl_pkg.
//
// Usage:
// Events enter on the request channel (func, byte_count, cpu_amount,
// open_connections, period_number) with req_valid/req_stall, and one result
// beat per event leaves on the response channel (verdict and the eight
// lifetime and throttle counters) with rsp_valid/rsp_stall.
// A beat lands in the input register, and from there the counters, verdict
// and rsp_valid are updated when the response register is free to take it;
// one event is taken every cycle while the receiver does not stall.
// The counter registers themselves carry the result, so they only change
// when a result is taken or the response register is empty.
// When the receiver stalls, the result holds and one further event is
// buffered in the input register; then req_stall rises.
// The user must write limits over the APB port while no event is in flight;
// the block does not enforce it. A synchronous reset clears all limits,
// gauges, stamps and counters and empties both registers.
module tenant_window_rate_limiter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [twrl_pkg::AddrW-1:0]            paddr,
  input  logic [twrl_pkg::DataW-1:0]            pwdata,
  output logic [twrl_pkg::DataW-1:0]            prdata,
  output logic                                  pready,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [2:0]                            func,
  input  logic [31:0]                           byte_count,
  input  logic [31:0]                           cpu_amount,
  input  logic [twrl_pkg::ConnW-1:0]            open_connections,
  input  logic [twrl_pkg::StampW-1:0]           period_number,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic [2:0]                            verdict,
  output logic [twrl_pkg::CntW-1:0]             total_sent,
  output logic [twrl_pkg::CntW-1:0]             total_received,
  output logic [twrl_pkg::CntW-1:0]             total_ops,
  output logic [twrl_pkg::CntW-1:0]             total_cpu,
  output logic [twrl_pkg::CntW-1:0]             throttled_ingress,
  output logic [twrl_pkg::CntW-1:0]             throttled_egress,
  output logic [twrl_pkg::CntW-1:0]             throttled_ops,
  output logic [twrl_pkg::CntW-1:0]             throttled_conns
);

  localparam int unsigned CW = twrl_pkg::CntW;
  localparam int unsigned SW = twrl_pkg::StampW;

  // Configuration registers.
  logic [twrl_pkg::MibW-1:0]  ingress_limit_mib;
  logic [twrl_pkg::MibW-1:0]  egress_limit_mib;
  logic [twrl_pkg::OpsW-1:0]  ops_limit;
  logic [twrl_pkg::ConnW-1:0] connection_limit;
  twrl_pkg::reg_idx_t         reg_idx;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = twrl_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ingress_limit_mib <= '0;
      egress_limit_mib  <= '0;
      ops_limit         <= '0;
      connection_limit  <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        twrl_pkg::REG_INGRESS_LIMIT: ingress_limit_mib <= pwdata[twrl_pkg::MibW-1:0];
        twrl_pkg::REG_EGRESS_LIMIT:  egress_limit_mib  <= pwdata[twrl_pkg::MibW-1:0];
        twrl_pkg::REG_OPS_LIMIT:     ops_limit         <= pwdata[twrl_pkg::OpsW-1:0];
        twrl_pkg::REG_CONN_LIMIT:    connection_limit  <= pwdata[twrl_pkg::ConnW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      twrl_pkg::REG_INGRESS_LIMIT:
        prdata = {{(twrl_pkg::DataW - twrl_pkg::MibW){1'b0}}, ingress_limit_mib};
      twrl_pkg::REG_EGRESS_LIMIT:
        prdata = {{(twrl_pkg::DataW - twrl_pkg::MibW){1'b0}}, egress_limit_mib};
      twrl_pkg::REG_OPS_LIMIT:
        prdata = ops_limit;
      twrl_pkg::REG_CONN_LIMIT:
        prdata = {{(twrl_pkg::DataW - twrl_pkg::ConnW){1'b0}}, connection_limit};
      default:
        prdata = '0;
    endcase
  end

  // Input register.
  logic                       in_valid;
  logic [2:0]                 in_func;
  logic [31:0]                in_bytes;
  logic [31:0]                in_cpu;
  logic [twrl_pkg::ConnW-1:0] in_conns;
  logic [SW-1:0]              in_period;
  logic                       advance;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!req_stall) begin
      in_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_func   <= func;
      in_bytes  <= byte_count;
      in_cpu    <= cpu_amount;
      in_conns  <= open_connections;
      in_period <= period_number;
    end
  end

  // Window gauges and counters.
  logic [CW-1:0] ingress_gauge, egress_gauge, ops_gauge;
  logic [SW-1:0] ingress_stamp, egress_stamp, ops_stamp;
  logic [CW-1:0] ingress_gauge_next, egress_gauge_next, ops_gauge_next;
  logic [SW-1:0] ingress_stamp_next, egress_stamp_next, ops_stamp_next;
  logic [CW-1:0] total_sent_next, total_received_next, total_ops_next, total_cpu_next;
  logic [CW-1:0] throttled_ingress_next, throttled_egress_next;
  logic [CW-1:0] throttled_ops_next, throttled_conns_next;
  logic [2:0]    verdict_next;

  logic [CW-1:0] in_cur, eg_cur, ops_cur;
  logic [CW-1:0] in_lim, eg_lim;
  logic          in_exc, eg_exc, ops_exc, conn_exc;
  logic [CW-1:0] bytes_ext;

  assign bytes_ext = {{(CW - 32){1'b0}}, in_bytes};

  // A gauge seen from another period reads as zero.
  assign in_cur  = (ingress_stamp == in_period) ? ingress_gauge : '0;
  assign eg_cur  = (egress_stamp  == in_period) ? egress_gauge  : '0;
  assign ops_cur = (ops_stamp     == in_period) ? ops_gauge     : '0;

  assign in_lim = {{(CW - twrl_pkg::MibW - twrl_pkg::MibSh){1'b0}}, ingress_limit_mib,
                   {twrl_pkg::MibSh{1'b0}}};
  assign eg_lim = {{(CW - twrl_pkg::MibW - twrl_pkg::MibSh){1'b0}}, egress_limit_mib,
                   {twrl_pkg::MibSh{1'b0}}};

  assign in_exc   = (ingress_limit_mib != '0) && (in_cur > in_lim);
  assign eg_exc   = (egress_limit_mib != '0) && (eg_cur > eg_lim);
  assign ops_exc  = (ops_limit != '0) && (ops_cur > {{(CW - twrl_pkg::OpsW){1'b0}}, ops_limit});
  assign conn_exc = (connection_limit != '0) && (in_conns > connection_limit);

  always_comb begin
    ingress_gauge_next     = ingress_gauge;
    egress_gauge_next      = egress_gauge;
    ops_gauge_next         = ops_gauge;
    ingress_stamp_next     = ingress_stamp;
    egress_stamp_next      = egress_stamp;
    ops_stamp_next         = ops_stamp;
    total_sent_next        = total_sent;
    total_received_next    = total_received;
    total_ops_next         = total_ops;
    total_cpu_next         = total_cpu;
    throttled_ingress_next = throttled_ingress;
    throttled_egress_next  = throttled_egress;
    throttled_ops_next     = throttled_ops;
    throttled_conns_next   = throttled_conns;
    verdict_next           = twrl_pkg::VERD_NONE;
    unique case (in_func)
      twrl_pkg::FUNC_SENT: begin
        total_sent_next   = total_sent + bytes_ext;
        egress_gauge_next = eg_cur + bytes_ext;
        egress_stamp_next = in_period;
      end
      twrl_pkg::FUNC_RECV: begin
        total_received_next = total_received + bytes_ext;
        ingress_gauge_next  = in_cur + bytes_ext;
        ingress_stamp_next  = in_period;
      end
      twrl_pkg::FUNC_OP: begin
        total_ops_next = total_ops + CW'(1);
        ops_gauge_next = ops_cur + CW'(1);
        ops_stamp_next = in_period;
      end
      twrl_pkg::FUNC_CHECK: begin
        // The check stops at the first exceeded limit, so later gauges
        // are only refreshed when it reaches them.
        ingress_gauge_next = in_cur;
        ingress_stamp_next = in_period;
        if (in_exc) begin
          verdict_next           = twrl_pkg::VERD_INGRESS;
          throttled_ingress_next = throttled_ingress + CW'(1);
        end else begin
          egress_gauge_next = eg_cur;
          egress_stamp_next = in_period;
          if (eg_exc) begin
            verdict_next          = twrl_pkg::VERD_EGRESS;
            throttled_egress_next = throttled_egress + CW'(1);
          end else begin
            ops_gauge_next = ops_cur;
            ops_stamp_next = in_period;
            if (ops_exc) begin
              verdict_next       = twrl_pkg::VERD_OPS;
              throttled_ops_next = throttled_ops + CW'(1);
            end else if (conn_exc) begin
              verdict_next         = twrl_pkg::VERD_CONNS;
              throttled_conns_next = throttled_conns + CW'(1);
            end
          end
        end
      end
      twrl_pkg::FUNC_CPU: begin
        total_cpu_next = total_cpu + {{(CW - 32){1'b0}}, in_cpu};
      end
      default: ;
    endcase
  end

  logic step;
  assign step = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid         <= 1'b0;
      verdict           <= twrl_pkg::VERD_NONE;
      ingress_gauge     <= '0;
      egress_gauge      <= '0;
      ops_gauge         <= '0;
      ingress_stamp     <= '0;
      egress_stamp      <= '0;
      ops_stamp         <= '0;
      total_sent        <= '0;
      total_received    <= '0;
      total_ops         <= '0;
      total_cpu         <= '0;
      throttled_ingress <= '0;
      throttled_egress  <= '0;
      throttled_ops     <= '0;
      throttled_conns   <= '0;
    end else begin
      if (advance) begin
        rsp_valid <= in_valid;
      end
      if (step) begin
        verdict           <= verdict_next;
        ingress_gauge     <= ingress_gauge_next;
        egress_gauge      <= egress_gauge_next;
        ops_gauge         <= ops_gauge_next;
        ingress_stamp     <= ingress_stamp_next;
        egress_stamp      <= egress_stamp_next;
        ops_stamp         <= ops_stamp_next;
        total_sent        <= total_sent_next;
        total_received    <= total_received_next;
        total_ops         <= total_ops_next;
        total_cpu         <= total_cpu_next;
        throttled_ingress <= throttled_ingress_next;
        throttled_egress  <= throttled_egress_next;
        throttled_ops     <= throttled_ops_next;
        throttled_conns   <= throttled_conns_next;
      end
    end
  end

endmodule

FILE: verif/tenant_window_rate_limiter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tenant_window_rate_limiter: directed and random event beats,
// APB limit writes with read-back, and a beat-by-beat compare of every result.
// Depends on twrl_pkg and the limiter RTL; needs no files or arguments.
module tenant_window_rate_limiter_tb;

  localparam int unsigned CntW   = twrl_pkg::CntW;
  localparam int unsigned StampW = twrl_pkg::StampW;
  localparam int unsigned MibW   = twrl_pkg::MibW;
  localparam int unsigned MibSh  = twrl_pkg::MibSh;
  localparam int unsigned OpsW   = twrl_pkg::OpsW;
  localparam int unsigned ConnW  = twrl_pkg::ConnW;
  localparam int unsigned AddrW  = twrl_pkg::AddrW;
  localparam int unsigned DataW  = twrl_pkg::DataW;

  localparam int CycleLimit = 400000;
  localparam int PrintCap   = 40;
  localparam int PhaseCount = 6;
  localparam int PhaseItems = 215;

  typedef struct {
    logic [2:0]      verd;
    logic [CntW-1:0] sent;
    logic [CntW-1:0] received;
    logic [CntW-1:0] ops;
    logic [CntW-1:0] cpu;
    logic [CntW-1:0] thr_in;
    logic [CntW-1:0] thr_out;
    logic [CntW-1:0] thr_ops;
    logic [CntW-1:0] thr_conn;
  } tally_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic [2:0]       func = '0;
  logic [31:0]      byte_count = '0;
  logic [31:0]      cpu_amount = '0;
  logic [ConnW-1:0] open_connections = '0;
  logic [StampW-1:0] period_number = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [2:0]       verdict;
  logic [CntW-1:0]  total_sent;
  logic [CntW-1:0]  total_received;
  logic [CntW-1:0]  total_ops;
  logic [CntW-1:0]  total_cpu;
  logic [CntW-1:0]  throttled_ingress;
  logic [CntW-1:0]  throttled_egress;
  logic [CntW-1:0]  throttled_ops;
  logic [CntW-1:0]  throttled_conns;

  tenant_window_rate_limiter dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .func(func), .byte_count(byte_count),
    .cpu_amount(cpu_amount), .open_connections(open_connections),
    .period_number(period_number),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .verdict(verdict),
    .total_sent(total_sent), .total_received(total_received), .total_ops(total_ops),
    .total_cpu(total_cpu), .throttled_ingress(throttled_ingress),
    .throttled_egress(throttled_egress), .throttled_ops(throttled_ops),
    .throttled_conns(throttled_conns)
  );

  // Predicted limiter state.
  logic [MibW-1:0]   lim_in_mib = '0;
  logic [MibW-1:0]   lim_out_mib = '0;
  logic [OpsW-1:0]   lim_ops = '0;
  logic [ConnW-1:0]  lim_conn = '0;
  logic [CntW-1:0]   gauge_in = '0;
  logic [CntW-1:0]   gauge_out = '0;
  logic [CntW-1:0]   gauge_ops = '0;
  logic [StampW-1:0] stamp_in = '0;
  logic [StampW-1:0] stamp_out = '0;
  logic [StampW-1:0] stamp_ops = '0;
  logic [CntW-1:0]   tot_sent = '0;
  logic [CntW-1:0]   tot_recv = '0;
  logic [CntW-1:0]   tot_ops = '0;
  logic [CntW-1:0]   tot_cpu = '0;
  logic [CntW-1:0]   thr_in = '0;
  logic [CntW-1:0]   thr_out = '0;
  logic [CntW-1:0]   thr_ops = '0;
  logic [CntW-1:0]   thr_conn = '0;

  tally_t expected_tallies[$];
  int verdicts_predicted[5];
  int mismatch_count = 0;
  int beats_checked = 0;
  int events_sent = 0;
  int limit_settings = 0;
  int cycle_count = 0;

  // Sender and receiver pacing.
  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int run_left = 0;
  logic run_stalled = 1'b0;
  logic [StampW-1:0] cur_period = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_tallies.size());
      $display("[tenant_window_rate_limiter] ERROR");
      $finish;
    end
  end

  function automatic logic [CntW-1:0] ceiling(logic [31:0] lim, int unsigned sh);
    return (lim == 0) ? {CntW{1'b1}} : (CntW'(lim) << sh);
  endfunction

  function automatic logic [CntW-1:0] window_value(logic [CntW-1:0] g, logic [StampW-1:0] s,
                                                    logic [StampW-1:0] per);
    return (s == per) ? g : '0;
  endfunction

  function automatic void account_event(logic [2:0] fn, logic [31:0] bytes, logic [31:0] cpu,
                                        logic [ConnW-1:0] conns, logic [StampW-1:0] per);
    twrl_pkg::verdict_t v;
    tally_t t;
    v = twrl_pkg::VERD_NONE;
    case (fn)
      twrl_pkg::FUNC_SENT: begin
        tot_sent += CntW'(bytes);
        gauge_out = window_value(gauge_out, stamp_out, per) + CntW'(bytes);
        stamp_out = per;
      end
      twrl_pkg::FUNC_RECV: begin
        tot_recv += CntW'(bytes);
        gauge_in = window_value(gauge_in, stamp_in, per) + CntW'(bytes);
        stamp_in = per;
      end
      twrl_pkg::FUNC_OP: begin
        gauge_ops = window_value(gauge_ops, stamp_ops, per) + 1;
        stamp_ops = per;
        tot_ops += 1;
      end
      twrl_pkg::FUNC_CHECK: begin
        // The check walks the gauges in priority order and stops at the first hit,
        // so a later gauge keeps its old window when an earlier one throttles.
        gauge_in = window_value(gauge_in, stamp_in, per);
        stamp_in = per;
        if (gauge_in > ceiling(32'(lim_in_mib), MibSh)) begin
          v = twrl_pkg::VERD_INGRESS;
          thr_in += 1;
        end else begin
          gauge_out = window_value(gauge_out, stamp_out, per);
          stamp_out = per;
          if (gauge_out > ceiling(32'(lim_out_mib), MibSh)) begin
            v = twrl_pkg::VERD_EGRESS;
            thr_out += 1;
          end else begin
            gauge_ops = window_value(gauge_ops, stamp_ops, per);
            stamp_ops = per;
            if (gauge_ops > ceiling(lim_ops, 0)) begin
              v = twrl_pkg::VERD_OPS;
              thr_ops += 1;
            end else if (CntW'(conns) > ceiling(32'(lim_conn), 0)) begin
              v = twrl_pkg::VERD_CONNS;
              thr_conn += 1;
            end
          end
        end
      end
      twrl_pkg::FUNC_CPU: begin
        tot_cpu += CntW'(cpu);
      end
      default: begin
      end
    endcase
    verdicts_predicted[int'(v)]++;
    t.verd = v;
    t.sent = tot_sent;
    t.received = tot_recv;
    t.ops = tot_ops;
    t.cpu = tot_cpu;
    t.thr_in = thr_in;
    t.thr_out = thr_out;
    t.thr_ops = thr_ops;
    t.thr_conn = thr_conn;
    expected_tallies.push_back(t);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PrintCap) $display("%0t ns: %s", $time, what);
  endtask

  task automatic compare_count(input string name, input logic [CntW-1:0] got,
                               input logic [CntW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    tally_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      beats_checked++;
      if (expected_tallies.size() == 0) begin
        report_mismatch("result beat arrived with nothing expected");
      end else begin
        want = expected_tallies.pop_front();
        compare_count("verdict", CntW'(verdict), CntW'(want.verd));
        compare_count("total_sent", total_sent, want.sent);
        compare_count("total_received", total_received, want.received);
        compare_count("total_ops", total_ops, want.ops);
        compare_count("total_cpu", total_cpu, want.cpu);
        compare_count("throttled_ingress", throttled_ingress, want.thr_in);
        compare_count("throttled_egress", throttled_egress, want.thr_out);
        compare_count("throttled_ops", throttled_ops, want.thr_ops);
        compare_count("throttled_conns", throttled_conns, want.thr_conn);
      end
    end
  end

  // The receiver stalls in random runs, or holds off for a whole requested stretch.
  always @(posedge clk) begin : drive_rsp_stall
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_stalled = ($urandom_range(99) < stall_pct);
        run_left = $urandom_range(5, 1);
      end
      run_left--;
      rsp_stall <= run_stalled;
    end
  end

  task automatic send_event(input logic [2:0] fn, input logic [31:0] bytes,
                            input logic [31:0] cpu, input logic [ConnW-1:0] conns,
                            input logic [StampW-1:0] per);
    req_valid <= 1'b1;
    func <= fn;
    byte_count <= bytes;
    cpu_amount <= cpu;
    open_connections <= conns;
    period_number <= per;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    account_event(fn, bytes, cpu, conns, per);
    events_sent++;
  endtask

  task automatic paced_send(input logic [2:0] fn, input logic [31:0] bytes,
                            input logic [31:0] cpu, input logic [ConnW-1:0] conns,
                            input logic [StampW-1:0] per);
    send_event(fn, bytes, cpu, conns, per);
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        req_valid <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input twrl_pkg::reg_idx_t idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] kept;
    case (idx)
      twrl_pkg::REG_INGRESS_LIMIT: begin
        lim_in_mib = value[MibW-1:0];
        kept = DataW'(lim_in_mib);
      end
      twrl_pkg::REG_EGRESS_LIMIT: begin
        lim_out_mib = value[MibW-1:0];
        kept = DataW'(lim_out_mib);
      end
      twrl_pkg::REG_OPS_LIMIT: begin
        lim_ops = value[OpsW-1:0];
        kept = DataW'(lim_ops);
      end
      default: begin
        lim_conn = value[ConnW-1:0];
        kept = DataW'(lim_conn);
      end
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // Back-to-back read of the same register.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    compare_count($sformatf("read-back of %s", idx.name()), CntW'(prdata), CntW'(kept));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_limits(input logic [MibW-1:0] in_mib, input logic [MibW-1:0] out_mib,
                                  input logic [OpsW-1:0] ops, input logic [ConnW-1:0] conns);
    write_limit(twrl_pkg::REG_INGRESS_LIMIT, {12'($urandom), in_mib});
    write_limit(twrl_pkg::REG_EGRESS_LIMIT, {12'($urandom), out_mib});
    write_limit(twrl_pkg::REG_OPS_LIMIT, ops);
    write_limit(twrl_pkg::REG_CONN_LIMIT, {16'($urandom), conns});
    limit_settings++;
  endtask

  task automatic random_event();
    int pick;
    logic [2:0] fn;
    logic [31:0] bytes;
    logic [StampW-1:0] per;
    logic [ConnW-1:0] conns;
    pick = $urandom_range(99);
    if (pick < 25) fn = twrl_pkg::FUNC_RECV;
    else if (pick < 50) fn = twrl_pkg::FUNC_SENT;
    else if (pick < 70) fn = twrl_pkg::FUNC_OP;
    else if (pick < 90) fn = twrl_pkg::FUNC_CHECK;
    else if (pick < 96) fn = twrl_pkg::FUNC_CPU;
    else fn = 3'($urandom_range(7, 5));
    pick = $urandom_range(99);
    if (pick < 3) cur_period++;
    else if (pick < 5) cur_period = $urandom;
    per = cur_period;
    if (pick >= 5 && pick < 8) per = cur_period - 1;
    pick = $urandom_range(99);
    if (pick < 12) bytes = $urandom;
    else if (pick < 17) bytes = '0;
    else bytes = $urandom_range(1 << 19);
    if ($urandom_range(99) < 15) conns = 16'($urandom);
    else conns = 16'($urandom_range(2 * int'(lim_conn) + 2));
    paced_send(fn, bytes, $urandom, conns, per);
  endtask

  task automatic test_each_function();
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, 16'hFFFF, '0);
    send_event(twrl_pkg::FUNC_SENT, 32'hFFFF_FFFF, '0, '0, '0);
    send_event(twrl_pkg::FUNC_RECV, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF);
    send_event(twrl_pkg::FUNC_OP, '0, '0, '0, 32'hFFFF_FFFF);
    send_event(twrl_pkg::FUNC_CPU, '0, 32'hFFFF_FFFF, '0, '0);
    send_event(twrl_pkg::FUNC_CPU, 32'hFFFF_FFFF, '0, 16'hFFFF, 32'h0000_0001);
    send_event(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd1);
    send_event(3'd6, 32'd77, 32'd5, 16'd3, 32'd2);
    send_event(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(twrl_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_limit_priority();
    write_limit(twrl_pkg::REG_INGRESS_LIMIT, 32'hABC0_0001);
    write_limit(twrl_pkg::REG_EGRESS_LIMIT, 32'd1);
    write_limit(twrl_pkg::REG_OPS_LIMIT, 32'd2);
    write_limit(twrl_pkg::REG_CONN_LIMIT, 32'h1234_000A);
    limit_settings++;
    // Gauges exactly at their limits do not throttle.
    send_event(twrl_pkg::FUNC_RECV, 32'd1 << 20, '0, '0, 32'd7);
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, 16'd10, 32'd7);
    send_event(twrl_pkg::FUNC_RECV, 32'd1, '0, '0, 32'd7);
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, 16'd10, 32'd7);
    send_event(twrl_pkg::FUNC_SENT, (32'd1 << 20) + 1, '0, '0, 32'd7);
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, 16'd11, 32'd7);
    // A new window clears every gauge the check reaches.
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, 16'd11, 32'd8);
    repeat (3) send_event(twrl_pkg::FUNC_OP, '0, '0, '0, 32'd8);
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, 16'd11, 32'd8);
    send_event(twrl_pkg::FUNC_SENT, 32'd2 << 20, '0, '0, 32'd8);
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, '0, 32'd8);
    // An ingress hit in window 9 leaves the egress gauge in window 8.
    send_event(twrl_pkg::FUNC_RECV, 32'd3 << 20, '0, '0, 32'd9);
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, '0, 32'd9);
    send_event(twrl_pkg::FUNC_SENT, 32'd1, '0, '0, 32'd8);
    send_event(twrl_pkg::FUNC_CHECK, '0, '0, '0, 32'd8);
    settle();
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    stall_pct = 0;
    hold_request = 80;
    repeat (40) random_event();
    settle();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase == 0) begin
        write_all_limits('0, '0, '0, '0);
      end else if (phase == 1) begin
        write_all_limits({MibW{1'b1}}, {MibW{1'b1}}, {OpsW{1'b1}}, {ConnW{1'b1}});
      end else begin
        write_all_limits(($urandom_range(4) == 0) ? '0 : MibW'($urandom_range(4, 1)),
                         ($urandom_range(4) == 0) ? '0 : MibW'($urandom_range(4, 1)),
                         ($urandom_range(4) == 0) ? '0 : OpsW'($urandom_range(40, 1)),
                         ($urandom_range(4) == 0) ? '0 : ConnW'($urandom_range(1000, 1)));
      end
      stall_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 35 : 65);
      gap_max = (phase == 2 || phase == 5) ? 0 : $urandom_range(8, 2);
      burst_left = 0;
      cur_period = (phase == 3) ? 32'hFFFF_FFF0 : $urandom;
      repeat (PhaseItems) random_event();
      settle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_each_function();
    test_limit_priority();
    test_backpressure();
    test_random_phases();
    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d events, %0d result beats, %0d limit settings, every func code",
             events_sent, beats_checked, limit_settings);
    $display("verdicts none %0d, ingress %0d, egress %0d, ops %0d, conns %0d",
             verdicts_predicted[0], verdicts_predicted[1], verdicts_predicted[2],
             verdicts_predicted[3], verdicts_predicted[4]);
    if (mismatch_count == 0) begin
      $display("[tenant_window_rate_limiter] OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[tenant_window_rate_limiter] ERROR");
    end
    $finish;
  end

endmodule
